// ===== design/cksum_pkg.sv =====
// ----------------------------------------------------------------------------
// cksum_pkg
// Shared types, constants and the byte fold of the cksum crc-32 unit.
// ----------------------------------------------------------------------------
package cksum_pkg;

    parameter int COUNT_BITS = 32;

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [0:0] {
        ST_IDLE   = 1'b0,
        ST_LENGTH = 1'b1
    } cksum_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take_word;
        logic fold_len;
        logic finish;
    } cksum_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic rest_zero;
        logic out_free;
    } cksum_stat_t;

    // one byte into the msb-first crc, eight shift steps
    function automatic logic [31:0] crc_fold(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        r = acc ^ {b, 24'h00_0000};
        for (int i = 0; i < 8; i++) begin
            if (r[31])
                r = (r << 1) ^ CRC_POLY;
            else
                r = r << 1;
        end
        return r;
    endfunction

endpackage

// ===== design/cksum_ctrl.sv =====
// ----------------------------------------------------------------------------
// cksum_ctrl
// Controller: takes words while idle, then walks the length bytes and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module cksum_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  end_of_message,
    input  cksum_pkg::cksum_stat_t stat,
    output logic                  in_ready,
    output cksum_pkg::cksum_cmd_t  cmd
);
    import cksum_pkg::*;

    cksum_state_t state_reg;
    cksum_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && end_of_message)
                    state_next = ST_LENGTH;
            end
            ST_LENGTH:
            begin
                if (stat.rest_zero && stat.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.take_word = 1'b0;
        cmd.fold_len = 1'b0;
        cmd.finish   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.take_word = in_valid;
            end
            ST_LENGTH:
            begin
                cmd.fold_len = !stat.rest_zero;
                cmd.finish   = stat.rest_zero && stat.out_free;
            end
            default: in_ready = 1'b0;
        endcase
    end

endmodule

// ===== design/cksum_dp.sv =====
// ----------------------------------------------------------------------------
// cksum_dp
// Datapath: crc accumulator, byte counter, length shifter and the
// output register.
// ----------------------------------------------------------------------------
module cksum_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cksum_pkg::cksum_cmd_t  cmd,
    input  logic [7:0]            data_byte,
    input  logic                  byte_present,
    input  logic                  end_of_message,
    input  logic                  out_ready,
    output cksum_pkg::cksum_stat_t stat,
    output logic                  out_valid,
    output logic [31:0]           checksum,
    output logic [31:0]           message_length,
    output logic                  length_saturated
);
    import cksum_pkg::*;

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    count_t      cnt_reg;
    count_t      cnt_next;
    logic        sat_reg;
    logic        sat_next;
    count_t      rest_reg;
    count_t      rest_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] sum_reg;
    logic [31:0] len_reg;
    logic        lsat_reg;

    count_t      cnt_inc;
    logic        cnt_full;
    logic [63:0] cnt_wide;
    logic        cnt_high;

    assign cnt_full = (cnt_reg == '1);
    assign cnt_inc  = cnt_full ? cnt_reg : cnt_reg + count_t'(1);
    assign cnt_wide = 64'(cnt_reg);
    assign cnt_high = |cnt_wide[63:32];

    assign stat.rest_zero = (rest_reg == '0);
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        crc_next       = crc_reg;
        cnt_next       = cnt_reg;
        sat_next       = sat_reg;
        rest_next      = rest_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.take_word)
        begin
            if (byte_present)
            begin
                crc_next = crc_fold(crc_reg, data_byte);
                cnt_next = cnt_inc;
                if (cnt_full)
                    sat_next = 1'b1;
            end
            // length to fold in, low byte first
            if (end_of_message)
                rest_next = byte_present ? cnt_inc : cnt_reg;
        end
        if (cmd.fold_len)
        begin
            crc_next  = crc_fold(crc_reg, rest_reg[7:0]);
            rest_next = rest_reg >> 8;
        end
        if (cmd.finish)
        begin
            crc_next       = '0;
            cnt_next       = '0;
            sat_next       = 1'b0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= '0;
            cnt_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            cnt_reg       <= cnt_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg <= rest_next;
        if (cmd.finish)
        begin
            sum_reg  <= ~crc_reg;
            len_reg  <= cnt_high ? 32'hFFFF_FFFF : cnt_wide[31:0];
            lsat_reg <= sat_reg || cnt_high;
        end
    end

    assign out_valid        = out_valid_reg;
    assign checksum         = sum_reg;
    assign message_length   = len_reg;
    assign length_saturated = lsat_reg;

endmodule

// ===== design/posix_cksum_crc32_unit.sv =====
// result: an end word gives its result once the length fold loop has folded in the bytes
//   of the byte count up to its highest nonzero byte (0 to 4 for 32 bits)
// throughput: one byte word per cycle; an end word blocks input until the length fold loop,
//   which uses the crc byte fold, is done, and longer while an earlier result still waits
//   at the output
// reset: asynchronous, clears accumulator, count, saturation flag and output valid
// ----------------------------------------------------------------------------
// posix_cksum_crc32_unit
// POSIX cksum crc-32 over a byte stream, with the length folded in at the end.
// ----------------------------------------------------------------------------
module posix_cksum_crc32_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] checksum,
    output logic [31:0] message_length,
    output logic        length_saturated
);
    import cksum_pkg::*;

    cksum_cmd_t  cmd;
    cksum_stat_t stat;

    cksum_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .end_of_message (end_of_message),
        .stat           (stat),
        .in_ready       (in_ready),
        .cmd            (cmd)
    );

    cksum_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .data_byte        (data_byte),
        .byte_present     (byte_present),
        .end_of_message   (end_of_message),
        .out_ready        (out_ready),
        .stat             (stat),
        .out_valid        (out_valid),
        .checksum         (checksum),
        .message_length   (message_length),
        .length_saturated (length_saturated)
    );

`ifndef NO_ASSERTIONS
    // a result never overwrites one still waiting
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid || out_ready))
        else $error("result captured over a pending one");

    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("finished result not shown");

    a_fold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fold_len |-> !in_ready)
        else $error("input open during length fold");

    a_end_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && end_of_message) |=> !in_ready)
        else $error("input open right after an end word");
`endif

endmodule
